### rtl/iwe_pkg.sv
// instruction word encoder package: payload structs, mnemonic indexes,
// opcodes, error codes and the alu opcode lookup
// no dependencies
package iwe_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int FIELD_ADDR_W  = 16;
    // label offset arithmetic width: enough for any 16-bit difference plus sign
    localparam int REL_W = FIELD_ADDR_W + 2;

    // mnemonic indexes
    localparam logic [4:0] K_MUL  = 5'd11;
    localparam logic [4:0] K_MULH = 5'd12;
    localparam logic [4:0] K_STF  = 5'd13;
    localparam logic [4:0] K_CLF  = 5'd14;
    localparam logic [4:0] K_PUSH = 5'd15;
    localparam logic [4:0] K_POP  = 5'd16;
    localparam logic [4:0] K_STS  = 5'd17;
    localparam logic [4:0] K_LDS  = 5'd18;
    localparam logic [4:0] K_RET  = 5'd19;
    localparam logic [4:0] K_HALT = 5'd20;
    localparam logic [4:0] K_MVI  = 5'd21;
    localparam logic [4:0] K_JZ   = 5'd22;
    localparam logic [4:0] K_CALR = 5'd23;
    localparam logic [4:0] K_JR   = 5'd24;
    localparam logic [4:0] K_STM  = 5'd25;
    localparam logic [4:0] K_LDM  = 5'd26;

    // opcodes
    localparam logic [5:0] OP6_MUL  = 6'h0E;
    localparam logic [5:0] OP6_MULH = 6'h0F;
    localparam logic [5:0] OP6_STF  = 6'h10;
    localparam logic [5:0] OP6_CLF  = 6'h11;
    localparam logic [5:0] OP6_PUSH = 6'h1C;
    localparam logic [5:0] OP6_POP  = 6'h1D;
    localparam logic [5:0] OP6_STS  = 6'h1E;
    localparam logic [5:0] OP6_LDS  = 6'h1F;
    localparam logic [3:0] OP4_STM_X = 4'h8;
    localparam logic [3:0] OP4_LDM_X = 4'h9;
    localparam logic [3:0] OP4_STM_Y = 4'hA;
    localparam logic [3:0] OP4_LDM_Y = 4'hB;
    localparam logic [3:0] OP4_MVI  = 4'hC;
    localparam logic [3:0] OP4_JZ   = 4'hD;
    localparam logic [3:0] OP4_CALR = 4'hE;
    localparam logic [3:0] OP4_JR   = 4'hF;
    localparam logic [15:0] WORD_RET  = 16'h7410;
    localparam logic [15:0] WORD_HALT = 16'hFFFF;

    // error codes
    localparam logic [2:0] E_OK      = 3'd0;
    localparam logic [2:0] E_UNKNOWN = 3'd1;
    localparam logic [2:0] E_ODD_POP = 3'd2;
    localparam logic [2:0] E_IMM     = 3'd3;
    localparam logic [2:0] E_LABEL   = 3'd4;
    localparam logic [2:0] E_REL8    = 3'd5;
    localparam logic [2:0] E_REL12   = 3'd6;

    typedef struct packed {
        logic [4:0]                kind;
        logic [3:0]                first_reg;
        logic [3:0]                second_reg;
        logic signed [11:0]        immediate;
        logic                      base_is_x;
        logic                      offset_is_label;
        logic                      label_found;
        logic [FIELD_ADDR_W-1:0]   label_address;
        logic [FIELD_ADDR_W-1:0]   word_position;
    } t_in;

    typedef struct packed {
        logic [15:0] machine_word;
        logic [2:0]  error_code;
    } t_out;

    // register-register alu opcodes; mul and mulh skip 0x0b..0x0d
    function automatic logic [5:0] alu_op(input logic [4:0] kind);
        logic [5:0] op;
        case (kind)
            K_MUL:   op = OP6_MUL;
            K_MULH:  op = OP6_MULH;
            default: op = {2'b00, kind[3:0]};
        endcase
        return op;
    endfunction

    function automatic logic [15:0] word_ri8(input logic [3:0] op4, input logic [3:0] reg_no,
                                             input logic [7:0] imm8);
        return {op4, imm8[7:4], reg_no, imm8[3:0]};
    endfunction

    function automatic logic [15:0] word_rel12(input logic [3:0] op4,
                                               input logic [11:0] rel);
        return {op4, rel[7:4], rel[11:8], rel[3:0]};
    endfunction

endpackage

### rtl/iwe_encode.sv
// instruction word encoder datapath: format select, range checks, bit packing
// depends on iwe_pkg
module iwe_encode
    import iwe_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  t_in  i_item,
    output t_out o_result
);

    localparam int EFF_W = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam logic [FIELD_ADDR_W-1:0] ADDR_MASK =
        FIELD_ADDR_W'((33'd1 << EFF_W) - 33'd1);

    logic [FIELD_ADDR_W-1:0] tgt;
    logic [FIELD_ADDR_W-1:0] pos;
    logic signed [REL_W-1:0] rel;
    logic signed [11:0]      imm;
    logic                    imm_s8_ok;
    logic                    rel8_ok;
    logic                    rel12_ok;
    logic [15:0]             word;
    logic [2:0]              err;
    logic [3:0]              op4;

    assign tgt = i_item.label_address & ADDR_MASK;
    assign pos = i_item.word_position & ADDR_MASK;
    assign rel = $signed({2'b00, tgt}) - $signed({2'b00, pos}) - REL_W'(1);
    assign imm = i_item.immediate;

    assign imm_s8_ok = (imm >= -12'sd128) && (imm <= 12'sd127);
    assign rel8_ok   = (rel >= -REL_W'(128)) && (rel <= REL_W'(127));
    assign rel12_ok  = (rel >= -REL_W'(2048)) && (rel <= REL_W'(2047));

    always_comb begin
        word = '0;
        err  = E_OK;
        op4  = OP4_JR;
        unique case (i_item.kind) inside
            [5'd0:K_MULH]: begin
                word = {alu_op(i_item.kind), 2'b00, i_item.first_reg, i_item.second_reg};
            end
            K_STF, K_CLF: begin
                if (imm < 12'sd0 || imm > 12'sd1) begin
                    err = E_IMM;
                end else begin
                    word = {(i_item.kind == K_STF) ? OP6_STF : OP6_CLF, 9'd0, imm[0]};
                end
            end
            K_PUSH, K_POP, K_STS, K_LDS: begin
                if (i_item.kind == K_POP && i_item.first_reg[0]) begin
                    err = E_ODD_POP;
                end else begin
                    word = {OP6_PUSH + {4'd0, i_item.kind[1:0] - K_PUSH[1:0]}, 2'b00,
                            i_item.first_reg, 4'd0};
                end
            end
            K_RET:  word = WORD_RET;
            K_HALT: word = WORD_HALT;
            K_MVI: begin
                if (imm < -12'sd128 || imm > 12'sd255) begin
                    err = E_IMM;
                end else begin
                    word = word_ri8(OP4_MVI, i_item.first_reg, imm[7:0]);
                end
            end
            K_JZ: begin
                if (i_item.offset_is_label) begin
                    if (!i_item.label_found) begin
                        err = E_LABEL;
                    end else if (!rel8_ok) begin
                        err = E_REL8;
                    end else begin
                        word = word_ri8(OP4_JZ, i_item.first_reg, rel[7:0]);
                    end
                end else if (!imm_s8_ok) begin
                    err = E_IMM;
                end else begin
                    word = word_ri8(OP4_JZ, i_item.first_reg, imm[7:0]);
                end
            end
            K_CALR, K_JR: begin
                op4 = (i_item.kind == K_CALR) ? OP4_CALR : OP4_JR;
                if (i_item.offset_is_label) begin
                    if (!i_item.label_found) begin
                        err = E_LABEL;
                    end else if (!rel12_ok) begin
                        err = E_REL12;
                    end else begin
                        word = word_rel12(op4, rel[11:0]);
                    end
                end else begin
                    word = word_rel12(op4, imm);
                end
            end
            K_STM, K_LDM: begin
                if (i_item.kind == K_STM) begin
                    op4 = i_item.base_is_x ? OP4_STM_X : OP4_STM_Y;
                end else begin
                    op4 = i_item.base_is_x ? OP4_LDM_X : OP4_LDM_Y;
                end
                if (!imm_s8_ok) begin
                    err = E_IMM;
                end else begin
                    word = word_ri8(op4, i_item.first_reg, imm[7:0]);
                end
            end
            default: err = E_UNKNOWN;
        endcase
        // an error always reports a zero word
        if (err != E_OK) begin
            word = '0;
        end
    end

    assign o_result.machine_word = word;
    assign o_result.error_code   = err;

endmodule

### rtl/instruction_word_encoder.sv
// instruction word encoder top level: input register, encode logic, result register
// depends on iwe_pkg and iwe_encode
// each instruction passes the input register, then the encode logic, then the result register
// throughput: one instruction per cycle; input stalls only when both registers are full
// reset: synchronous active-low i_rst_n clears both stage valid flags
module instruction_word_encoder
    import iwe_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;
    t_out n_out_data;
    logic adv_out;
    logic adv_in;

    // each stage moves when the one after it can take its contents
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_in     = !r_in_valid || adv_out;
    assign o_in_stall = !adv_in;

    iwe_encode #(
        .ADDR_BITS(ADDR_BITS)
    ) u_encode (
        .i_item  (r_in_data),
        .o_result(n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (adv_in && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (adv_out && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### bench/testbench.sv
// self-checking bench for instruction_word_encoder: directed corner cases, then random
// instructions with random gaps and stalls on both sides, each word predicted and compared
// depends on iwe_pkg and the instruction_word_encoder rtl
module testbench;
    import iwe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TB_ADDR_BITS  = ADDR_BITS_DEF;
    localparam logic [31:0] ADDR_MASK     = 32'((64'd1 << TB_ADDR_BITS) - 1);
    localparam int          RANDOM_COUNT  = 1150;
    localparam int          IDLE_LIMIT    = 5000;
    localparam int          PRINT_LIMIT   = 40;

    // mnemonic indexes the package leaves unnamed
    localparam logic [4:0] K_MOV           = 5'd0;
    localparam logic [4:0] K_FIRST_UNKNOWN = K_LDM + 5'd1;
    localparam logic [4:0] K_TOP_UNKNOWN   = 5'd31;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_in  pending_instrs[$];
    t_out predicted_words[$];

    int   fail_count   = 0;
    int   sent_count   = 0;
    int   words_count  = 0;
    int   error_tally[8];
    logic [31:0] kinds_sent = '0;
    int   in_gap = 0, in_calm = 0, out_hold = 0, out_calm = 0;
    int   idle_cycles = 0;

    instruction_word_encoder #(.ADDR_BITS(TB_ADDR_BITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] pack_ri8(logic [3:0] op4, logic [3:0] rg, logic [7:0] b8);
        return {op4, b8[7:4], rg, b8[3:0]};
    endfunction

    function automatic logic [15:0] pack_rel12(logic [3:0] op4, logic [11:0] r12);
        return {op4, r12[7:4], r12[11:8], r12[3:0]};
    endfunction

    // expected word and error code for one instruction
    function automatic t_out encode_instruction(input t_in it);
        t_out       res;
        int         imm;
        int         rel;
        logic [5:0] op6;
        logic [3:0] op4;
        res.machine_word = '0;
        res.error_code   = E_OK;
        imm = int'($signed(it.immediate));
        rel = int'(32'(it.label_address) & ADDR_MASK) - int'(32'(it.word_position) & ADDR_MASK) - 1;
        if (it.kind <= K_MULH) begin
            if (it.kind == K_MUL)       op6 = OP6_MUL;
            else if (it.kind == K_MULH) op6 = OP6_MULH;
            else                        op6 = {1'b0, it.kind};
            res.machine_word = {op6, 2'b00, it.first_reg, it.second_reg};
        end else if (it.kind == K_STF || it.kind == K_CLF) begin
            if (imm < 0 || imm > 1) begin
                res.error_code = E_IMM;
            end else begin
                op6 = (it.kind == K_STF) ? OP6_STF : OP6_CLF;
                res.machine_word = {op6, 9'd0, 1'(imm)};
            end
        end else if (it.kind >= K_PUSH && it.kind <= K_LDS) begin
            case (it.kind)
                K_PUSH:  op6 = OP6_PUSH;
                K_POP:   op6 = OP6_POP;
                K_STS:   op6 = OP6_STS;
                default: op6 = OP6_LDS;
            endcase
            if (it.kind == K_POP && it.first_reg[0])
                res.error_code = E_ODD_POP;
            else
                res.machine_word = {op6, 2'b00, it.first_reg, 4'h0};
        end else if (it.kind == K_RET) begin
            res.machine_word = WORD_RET;
        end else if (it.kind == K_HALT) begin
            res.machine_word = WORD_HALT;
        end else if (it.kind == K_MVI) begin
            if (imm < -128 || imm > 255)
                res.error_code = E_IMM;
            else
                res.machine_word = pack_ri8(OP4_MVI, it.first_reg, 8'(imm));
        end else if (it.kind == K_JZ) begin
            if (it.offset_is_label) begin
                if (!it.label_found)
                    res.error_code = E_LABEL;
                else if (rel < -128 || rel > 127)
                    res.error_code = E_REL8;
                else
                    res.machine_word = pack_ri8(OP4_JZ, it.first_reg, 8'(rel));
            end else if (imm < -128 || imm > 127) begin
                res.error_code = E_IMM;
            end else begin
                res.machine_word = pack_ri8(OP4_JZ, it.first_reg, 8'(imm));
            end
        end else if (it.kind == K_CALR || it.kind == K_JR) begin
            op4 = (it.kind == K_CALR) ? OP4_CALR : OP4_JR;
            if (it.offset_is_label) begin
                if (!it.label_found)
                    res.error_code = E_LABEL;
                else if (rel < -2048 || rel > 2047)
                    res.error_code = E_REL12;
                else
                    res.machine_word = pack_rel12(op4, 12'(rel));
            end else begin
                res.machine_word = pack_rel12(op4, 12'(imm));
            end
        end else if (it.kind == K_STM || it.kind == K_LDM) begin
            if (it.kind == K_STM) op4 = it.base_is_x ? OP4_STM_X : OP4_STM_Y;
            else                  op4 = it.base_is_x ? OP4_LDM_X : OP4_LDM_Y;
            if (imm < -128 || imm > 127)
                res.error_code = E_IMM;
            else
                res.machine_word = pack_ri8(op4, it.first_reg, 8'(imm));
        end else begin
            res.error_code = E_UNKNOWN;
        end
        if (res.error_code != E_OK)
            res.machine_word = '0;
        return res;
    endfunction

    function automatic t_in make_instr(logic [4:0] kind, int r1, int r2, int imm, bit x,
                                       bit lbl, bit found, int addr, int pos);
        t_in it;
        it.kind            = kind;
        it.first_reg       = 4'(r1);
        it.second_reg      = 4'(r2);
        it.immediate       = 12'(imm);
        it.base_is_x       = x;
        it.offset_is_label = lbl;
        it.label_found     = found;
        it.label_address   = 16'(addr);
        it.word_position   = 16'(pos);
        return it;
    endfunction

    // mostly known mnemonics with operands near the range limits
    function automatic t_in random_instr();
        t_in it;
        int  imm;
        int  rel;
        int  edges_imm[8] = '{-2048, 2047, -129, -128, 127, 128, 255, 256};
        int  edges_rel[6] = '{-2049, -2048, 2047, 2048, -129, 128};
        if ($urandom_range(0, 9) == 0)
            it.kind = 5'($urandom_range(int'(K_FIRST_UNKNOWN), int'(K_TOP_UNKNOWN)));
        else
            it.kind = 5'($urandom_range(0, int'(K_LDM)));
        it.first_reg       = 4'($urandom);
        it.second_reg      = 4'($urandom);
        it.base_is_x       = 1'($urandom);
        it.offset_is_label = 1'($urandom);
        it.label_found     = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2: imm = $urandom_range(0, 3) - 1;
            3, 4, 5: imm = $urandom_range(0, 383) - 128;
            6, 7:    imm = edges_imm[$urandom_range(0, 7)];
            default: imm = $urandom_range(0, 4095) - 2048;
        endcase
        it.immediate     = 12'(imm);
        it.word_position = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: rel = $urandom_range(0, 255) - 128;
            6, 7:             rel = $urandom_range(0, 4095) - 2048;
            8:                rel = edges_rel[$urandom_range(0, 5)];
            default:          rel = $urandom_range(0, 65535) - int'(it.word_position) - 1;
        endcase
        it.label_address = 16'(int'(it.word_position) + 1 + rel);
        return it;
    endfunction

    // mostly short gaps, some long ones, and now and then a calm stretch with none
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // driver: instruction channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_words.push_back(encode_instruction(i_in_data));
                kinds_sent[i_in_data.kind] = 1'b1;
                sent_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0 || pending_instrs.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (in_gap > 0) in_gap--;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_instrs.pop_front();
                    in_gap = draw_gap(in_calm);
                end
            end
        end
    end

    // monitor: result channel
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                words_count++;
                error_tally[o_out_data.error_code]++;
                if (predicted_words.size() == 0) begin
                    report_mismatch("unexpected result transfer", o_out_data, 0);
                end else begin
                    want = predicted_words.pop_front();
                    if (o_out_data.machine_word !== want.machine_word)
                        report_mismatch("machine_word", o_out_data.machine_word,
                                        want.machine_word);
                    if (o_out_data.error_code !== want.error_code)
                        report_mismatch("error_code", o_out_data.error_code, want.error_code);
                end
            end
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else begin
                i_out_stall <= 1'b0;
                out_hold = draw_gap(out_calm);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        // directed corner cases
        pending_instrs.push_back(make_instr(K_MOV, 0, 0, 0, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_MUL, 15, 15, 0, 1, 1, 1, 65535, 65535));
        pending_instrs.push_back(make_instr(K_MULH, 5, 10, -1, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_TOP_UNKNOWN, 15, 15, 2047, 1, 1, 1, 0, 0));
        pending_instrs.push_back(make_instr(K_POP, 1, 0, 0, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_POP, 14, 3, 0, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_STF, 0, 0, 1, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_CLF, 0, 0, 2, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_MVI, 3, 0, -128, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_MVI, 15, 0, 255, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_MVI, 2, 0, 256, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_JZ, 4, 0, -129, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_JZ, 4, 0, 127, 0, 0, 0, 0, 256));
        // label branches: offset is target minus the next word's address
        pending_instrs.push_back(make_instr(K_JZ, 7, 0, 0, 0, 1, 1, 384, 256));
        pending_instrs.push_back(make_instr(K_JZ, 7, 0, 0, 0, 1, 1, 128, 256));
        pending_instrs.push_back(make_instr(K_JZ, 7, 0, 0, 0, 1, 0, 300, 256));
        pending_instrs.push_back(make_instr(K_JR, 0, 0, -2048, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_CALR, 0, 0, 2047, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_JR, 0, 0, 0, 0, 1, 1, 2048, 0));
        pending_instrs.push_back(make_instr(K_CALR, 0, 0, 0, 0, 1, 1, 1952, 4000));
        pending_instrs.push_back(make_instr(K_JR, 0, 0, 0, 0, 1, 1, 0, 65535));
        pending_instrs.push_back(make_instr(K_CALR, 0, 0, 5, 0, 1, 0, 10, 20));
        pending_instrs.push_back(make_instr(K_STM, 15, 0, -128, 1, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_LDM, 9, 0, 128, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_LDM, 9, 0, 127, 1, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_RET, 0, 0, 0, 0, 0, 0, 0, 256));
        pending_instrs.push_back(make_instr(K_HALT, 0, 0, 0, 0, 0, 0, 0, 256));
        repeat (RANDOM_COUNT) pending_instrs.push_back(random_instr());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_instrs.size() != 0 || i_in_valid || predicted_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d instructions over %0d distinct mnemonic indexes, %0d words checked",
                 sent_count, $countones(kinds_sent), words_count);
        $display("error codes seen: ok %0d, unknown %0d, odd pop %0d, imm %0d, label %0d, "
                 , error_tally[E_OK], error_tally[E_UNKNOWN], error_tally[E_ODD_POP],
                 error_tally[E_IMM], error_tally[E_LABEL],
                 "rel8 %0d, rel12 %0d", error_tally[E_REL8], error_tally[E_REL12]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
